// File: sv/tts_pkg.sv
// Shared constants and types for the terminal screen writer.
`default_nettype none
package tts_pkg;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] BLANK    = 8'h20;

    localparam logic REQ_PUT  = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic REG_NEWLINE  = 1'b0;
    localparam logic REG_AUTOWRAP = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } sweep_stat_t;

endpackage
`default_nettype wire

// File: sv/text_terminal_screen_writer.sv
// Top level of the character-cell terminal screen writer.
// Each input beat is one request: a put of one byte (text or one of the
// control codes BEL, BS, CR, LF) or a read of one visible cell. Every request
// gives exactly one result beat with the cursor after the request, the cell
// read, the bell flag, the number of scrolls and an echo of block_end. The
// screen lives in a single-port RAM of ROWS*COLS bytes used as a ring of
// rows, so a scroll only moves the top-line pointer and blanks one row. One
// small sequencer owns the RAM port and a shared sweep counter does all the
// blanking. A read waits for the registered RAM read, and a CR, LF or wrap
// passes through a line step that does each cursor line feed and, on the
// last row, each scroll, in which the sweep blanks the COLS cells of the row.
// After reset the sweep clears the whole screen before the first beat is
// accepted; APB writes are taken during that time. The next request is
// accepted once the result is loaded into the output register, even if it is
// not yet taken.
`default_nettype none
module text_terminal_screen_writer #(
    parameter int ROWS = 32,
    parameter int COLS = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_char_code,
    input  wire logic [4:0]  s_read_row,
    input  wire logic [6:0]  s_read_col,
    input  wire logic        s_block_end,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [4:0]  m_cursor_row,
    output logic      [6:0]  m_cursor_col,
    output logic      [7:0]  m_cell_value,
    output logic             m_bell,
    output logic      [1:0]  m_scrolled,
    output logic             m_block_done
);
    localparam int TOTAL = ROWS * COLS;
    localparam int AW    = $clog2(TOTAL);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_LF     = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    // ---------------- config registers ----------------
    logic newline_reg, newline_next;
    logic autowrap_reg, autowrap_next;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        newline_next  = newline_reg;
        autowrap_next = autowrap_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                tts_pkg::REG_NEWLINE:  newline_next  = pwdata[0];
                tts_pkg::REG_AUTOWRAP: autowrap_next = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tts_pkg::REG_NEWLINE:  prdata = {31'd0, newline_reg};
            tts_pkg::REG_AUTOWRAP: prdata = {31'd0, autowrap_reg};
            default:               prdata = '0;
        endcase
    end

    // ---------------- sequencer state ----------------
    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] top_reg, top_next;
    logic [1:0]    pend_reg, pend_next;      // line feeds still to do
    logic [1:0]    scrolls_reg, scrolls_next;
    logic          bell_reg, bell_next;
    logic [7:0]    cell_reg, cell_next;

    // latched request
    logic          req_reg;
    logic [7:0]    char_reg;
    logic [4:0]    rrow_reg;
    logic [6:0]    rcol_reg;
    logic          bend_reg;

    // result register
    logic          m_valid_reg, m_valid_next;
    logic [4:0]    m_row_reg;
    logic [6:0]    m_col_reg;
    logic [7:0]    m_cell_reg;
    logic          m_bell_reg;
    logic [1:0]    m_scr_reg;
    logic          m_done_reg;
    logic          out_load;

    // sweep unit and RAM port
    tts_pkg::sweep_stat_t sw_stat;
    logic          sw_start;
    logic [AW-1:0] sw_base;
    logic [AW-1:0] sw_addr;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    // ---------------- address math ----------------
    logic          in_range;
    logic [RW-1:0] rrow_idx;
    logic [CW-1:0] rcol_idx;
    logic [RW:0]   rd_sum;
    logic [RW-1:0] rd_srow;
    logic [RW:0]   wr_sum;
    logic [RW-1:0] wr_srow;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          col_last, row_last;
    logic          is_print;
    logic [31:0]   row_ext, col_ext;

    assign in_range = (32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLS);
    assign rrow_idx = RW'(32'(rrow_reg));
    assign rcol_idx = CW'(32'(rcol_reg));

    // ring of rows: visible row + top, wrapped once
    assign rd_sum  = {1'b0, top_reg} + {1'b0, rrow_idx};
    assign rd_srow = (32'(rd_sum) >= ROWS) ? RW'(32'(rd_sum) - ROWS) : RW'(rd_sum);
    assign wr_sum  = {1'b0, top_reg} + {1'b0, row_reg};
    assign wr_srow = (32'(wr_sum) >= ROWS) ? RW'(32'(wr_sum) - ROWS) : RW'(wr_sum);

    assign rd_addr = AW'(32'(rd_srow) * COLS + 32'(rcol_idx));
    assign wr_addr = AW'(32'(wr_srow) * COLS + 32'(col_reg));
    assign sw_base = AW'(32'(top_reg) * COLS);

    assign col_last = !(32'(col_reg) + 32'd1 < COLS);
    assign row_last = !(32'(row_reg) + 32'd1 < ROWS);
    assign is_print = (char_reg != tts_pkg::CODE_BEL) && (char_reg != tts_pkg::CODE_BS)
                   && (char_reg != tts_pkg::CODE_CR)  && (char_reg != tts_pkg::CODE_LF);

    assign sw_start = (state_reg == ST_LF) && (pend_reg != 2'd0) && row_last;

    // sweep owns the port while busy; otherwise the sequencer reads or writes
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = rd_addr;
        ram_wdata = char_reg;
        if (sw_stat.busy) begin
            ram_we    = 1'b1;
            ram_addr  = sw_addr;
            ram_wdata = tts_pkg::BLANK;
        end else if (state_reg == ST_EXEC && req_reg == tts_pkg::REQ_PUT) begin
            ram_we   = is_print;
            ram_addr = wr_addr;
        end
    end

    function automatic logic [RW-1:0] row_last_top(input logic [RW-1:0] t);
        logic [31:0] nt;
        nt = 32'(t) + 32'd1;
        return (nt == ROWS) ? '0 : RW'(nt);
    endfunction

    // ---------------- sequencer ----------------
    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        top_next     = top_reg;
        pend_next    = pend_reg;
        scrolls_next = scrolls_reg;
        bell_next    = bell_reg;
        cell_next    = cell_reg;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                if (sw_stat.done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    scrolls_next = 2'd0;
                    bell_next    = 1'b0;
                    cell_next    = 8'd0;
                    pend_next    = 2'd0;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FIN;
                if (req_reg == tts_pkg::REQ_READ) begin
                    if (in_range) begin
                        state_next = ST_RDWAIT;
                    end
                end else begin
                    case (char_reg)
                        tts_pkg::CODE_BEL: bell_next = 1'b1;
                        tts_pkg::CODE_BS: begin
                            if (col_reg != '0) begin
                                col_next = col_reg - CW'(1);
                            end
                        end
                        tts_pkg::CODE_CR: begin
                            col_next   = '0;
                            pend_next  = {1'b0, newline_reg};
                            state_next = ST_LF;
                        end
                        tts_pkg::CODE_LF: begin
                            pend_next  = 2'd1;
                            state_next = ST_LF;
                        end
                        default: begin
                            if (!col_last) begin
                                col_next = col_reg + CW'(1);
                            end else if (autowrap_reg) begin
                                // implied CR then LF
                                col_next   = '0;
                                pend_next  = newline_reg ? 2'd2 : 2'd1;
                                state_next = ST_LF;
                            end
                        end
                    endcase
                end
            end
            ST_RDWAIT: begin
                cell_next  = ram_rdata;
                state_next = ST_FIN;
            end
            ST_LF: begin
                if (pend_reg == 2'd0) begin
                    state_next = ST_FIN;
                end else if (!row_last) begin
                    row_next  = row_reg + RW'(1);
                    pend_next = pend_reg - 2'd1;
                end else begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (sw_stat.done) begin
                    top_next     = row_last_top(top_reg);
                    scrolls_next = scrolls_reg + 2'd1;
                    pend_next    = pend_reg - 2'd1;
                    state_next   = ST_LF;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign row_ext = 32'(row_reg);
    assign col_ext = 32'(col_reg);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            newline_reg  <= 1'b1;
            autowrap_reg <= 1'b1;
            row_reg      <= '0;
            col_reg      <= '0;
            top_reg      <= '0;
            pend_reg     <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            newline_reg  <= newline_next;
            autowrap_reg <= autowrap_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            top_reg      <= top_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        scrolls_reg <= scrolls_next;
        bell_reg    <= bell_next;
        cell_reg    <= cell_next;
        if (s_valid && s_ready) begin
            req_reg  <= s_req_type;
            char_reg <= s_char_code;
            rrow_reg <= s_read_row;
            rcol_reg <= s_read_col;
            bend_reg <= s_block_end;
        end
        if (out_load) begin
            m_row_reg  <= row_ext[4:0];
            m_col_reg  <= col_ext[6:0];
            m_cell_reg <= cell_reg;
            m_bell_reg <= bell_reg;
            m_scr_reg  <= scrolls_reg;
            m_done_reg <= bend_reg;
        end
    end

    tts_sweep #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_sweep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sw_start),
        .base    (sw_base),
        .stat    (sw_stat),
        .addr    (sw_addr)
    );

    tts_ram #(
        .WIDTH (8),
        .DEPTH (TOTAL)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_cursor_row = m_row_reg;
    assign m_cursor_col = m_col_reg;
    assign m_cell_value = m_cell_reg;
    assign m_bell       = m_bell_reg;
    assign m_scrolled   = m_scr_reg;
    assign m_block_done = m_done_reg;
endmodule
`default_nettype wire

// File: sv/tts_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// File: sv/tts_sweep.sv
// Blanking sweep: walks the screen store one cell per cycle.
`default_nettype none
module tts_sweep #(
    parameter int ROWS = 32,
    parameter int COLS = 128
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [$clog2(ROWS*COLS)-1:0]  base,
    output tts_pkg::sweep_stat_t               stat,
    output logic      [$clog2(ROWS*COLS)-1:0]  addr
);
    localparam int TOTAL = ROWS * COLS;
    localparam int AW    = $clog2(TOTAL);

    logic          busy_reg, busy_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] remain_reg, remain_next;
    logic          last;

    assign last = (remain_reg == '0);

    always_comb begin
        busy_next   = busy_reg;
        addr_next   = addr_reg;
        remain_next = remain_reg;
        if (start) begin
            busy_next   = 1'b1;
            addr_next   = base;
            remain_next = AW'(COLS - 1);
        end else if (busy_reg) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                addr_next   = addr_reg + AW'(1);
                remain_next = remain_reg - AW'(1);
            end
        end
    end

    // reset starts a full-screen sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b1;
            addr_reg   <= '0;
            remain_reg <= AW'(TOTAL - 1);
        end else begin
            busy_reg   <= busy_next;
            addr_reg   <= addr_next;
            remain_reg <= remain_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg & last;
    assign addr      = addr_reg;
endmodule
`default_nettype wire

// File: sv/tts_checker.sv
// Port-level checks for the terminal screen writer, bound to the top level.
`default_nettype none
module tts_checker #(
    parameter int ROWS = 32
) (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [4:0] m_cursor_row,
    input wire logic [6:0] m_cursor_col,
    input wire logic [7:0] m_cell_value,
    input wire logic       m_bell,
    input wire logic [1:0] m_scrolled
);
    localparam logic [31:0] LAST_ROW = 32'(ROWS - 1);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_row)
            && $stable(m_cursor_col) && $stable(m_cell_value))
        else $error("result beat changed while stalled");

    // one request at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted back to back");

    a_bell: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bell |-> m_scrolled == 2'd0 && m_cell_value == 8'd0)
        else $error("bell beat with scroll or cell data");

    a_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scrolled != 2'd0 |->
            m_cursor_row == LAST_ROW[4:0] && m_scrolled != 2'd3)
        else $error("scroll without cursor on last row");
endmodule

bind text_terminal_screen_writer tts_checker #(
    .ROWS (ROWS)
) u_tts_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_cursor_row (m_cursor_row),
    .m_cursor_col (m_cursor_col),
    .m_cell_value (m_cell_value),
    .m_bell       (m_bell),
    .m_scrolled   (m_scrolled)
);
`default_nettype wire

// File: test/tts_screen_checker.sv
// Result checker for the terminal screen writer: shadow screen, cursor and compare.
`default_nettype none
module tts_screen_checker #(
    parameter int ROWS = 32,
    parameter int COLS = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_char_code,
    input  wire logic [4:0]  s_read_row,
    input  wire logic [6:0]  s_read_col,
    input  wire logic        s_block_end,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [4:0]  m_cursor_row,
    input  wire logic [6:0]  m_cursor_col,
    input  wire logic [7:0]  m_cell_value,
    input  wire logic        m_bell,
    input  wire logic [1:0]  m_scrolled,
    input  wire logic        m_block_done,
    output int               fail_count,
    output int               pending_results
);

    typedef struct packed {
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] cell_byte;
        logic       bell;
        logic [1:0] scrolls;
        logic       done;
    } screen_result_t;

    logic [7:0]     screen_shadow [ROWS][COLS];
    int unsigned    cur_row;
    int unsigned    cur_col;
    int unsigned    top_line;
    logic           newline_on;
    logic           wrap_on;
    screen_result_t expected_results [$];
    int             results_seen;

    initial begin
        fail_count      = 0;
        pending_results = 0;
        results_seen    = 0;
    end

    task automatic flag_mismatch(input string what);
        fail_count++;
        $display("ERROR @%0t result %0d: %s", $time, results_seen, what);
    endtask

    task automatic check_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", field, got, want));
        end
    endtask

    // line feed; on the last row the ring advances and the old top row is blanked
    function automatic logic [1:0] advance_line();
        if (cur_row + 1 < ROWS) begin
            cur_row++;
            return 2'd0;
        end
        for (int c = 0; c < COLS; c++) screen_shadow[top_line][c] = tts_pkg::BLANK;
        top_line = (top_line + 1) % ROWS;
        cur_row  = ROWS - 1;
        return 2'd1;
    endfunction

    function automatic logic [1:0] return_carriage();
        cur_col = 0;
        return newline_on ? advance_line() : 2'd0;
    endfunction

    function automatic screen_result_t predict_beat(input logic req, input logic [7:0] ch,
                                                    input logic [4:0] rrow,
                                                    input logic [6:0] rcol,
                                                    input logic last);
        screen_result_t res;
        logic [1:0]     nscroll;
        res     = '0;
        nscroll = 2'd0;
        if (req == tts_pkg::REQ_READ) begin
            if (rrow < ROWS && rcol < COLS)
                res.cell_byte = screen_shadow[(top_line + rrow) % ROWS][rcol];
        end else begin
            case (ch)
                tts_pkg::CODE_BEL: res.bell = 1'b1;
                tts_pkg::CODE_BS: begin
                    if (cur_col > 0) cur_col--;
                end
                tts_pkg::CODE_CR: nscroll += return_carriage();
                tts_pkg::CODE_LF: nscroll += advance_line();
                default: begin
                    screen_shadow[(top_line + cur_row) % ROWS][cur_col] = ch;
                    if (cur_col + 1 < COLS) begin
                        cur_col++;
                    end else if (wrap_on) begin
                        // implied CR then LF: two rows down in newline mode
                        nscroll += return_carriage();
                        nscroll += advance_line();
                    end
                end
            endcase
        end
        res.row     = cur_row[4:0];
        res.col     = cur_col[6:0];
        res.scrolls = nscroll;
        res.done    = last;
        return res;
    endfunction

    always @(posedge aclk) begin
        screen_result_t want;
        if (!aresetn) begin
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < COLS; c++) screen_shadow[r][c] = tts_pkg::BLANK;
            cur_row    = 0;
            cur_col    = 0;
            top_line   = 0;
            newline_on = 1'b1;
            wrap_on    = 1'b1;
            expected_results.delete();
            pending_results <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == tts_pkg::REG_NEWLINE) newline_on = pwdata[0];
                else                                  wrap_on    = pwdata[0];
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_beat(s_req_type, s_char_code,
                                                        s_read_row, s_read_col,
                                                        s_block_end));
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    flag_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("cursor_row", 8'(m_cursor_row), 8'(want.row));
                    check_field("cursor_col", 8'(m_cursor_col), 8'(want.col));
                    check_field("cell_value", m_cell_value, want.cell_byte);
                    check_field("bell", 8'(m_bell), 8'(want.bell));
                    check_field("scrolled", 8'(m_scrolled), 8'(want.scrolls));
                    check_field("block_done", 8'(m_block_done), 8'(want.done));
                end
            end
            pending_results <= expected_results.size();
        end
    end

endmodule
`default_nettype wire

// File: test/tb_text_terminal_screen_writer.sv
// Testbench top for the terminal screen writer: stimulus, pacing and verdict.
`default_nettype none
module tb_text_terminal_screen_writer;

    localparam int ROWS           = 32;
    localparam int COLS           = 128;
    localparam int PHASE_BEATS    = 320;
    localparam int NUM_PHASES     = 5;
    // long enough for the power-on sweep plus a pressure hold
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;
    // two scrolls worth of blanking plus pipeline
    localparam int DRAIN_CYCLES   = 2 * (COLS + 2) + 16;
    // per phase settings, bit p belongs to phase p
    localparam bit [NUM_PHASES-1:0] NEWLINE_PLAN  = 5'b10101;
    localparam bit [NUM_PHASES-1:0] AUTOWRAP_PLAN = 5'b10011;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;
    logic        s_valid;
    wire         s_ready;
    logic        s_req_type;
    logic [7:0]  s_char_code;
    logic [4:0]  s_read_row;
    logic [6:0]  s_read_col;
    logic        s_block_end;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [4:0]  m_cursor_row;
    wire  [6:0]  m_cursor_col;
    wire  [7:0]  m_cell_value;
    wire         m_bell;
    wire  [1:0]  m_scrolled;
    wire         m_block_done;

    int fail_count;
    int pending_results;
    int beats_sent   = 0;
    int idle_cycles  = 0;
    int gap_calm     = 0;   // sender: beats left in a no-gap stretch
    int hold_requests = 0;  // bumped by stimulus to ask for a long receiver hold
    int hold_seen    = 0;
    int stall_left   = 0;
    int ready_calm   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    text_terminal_screen_writer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_char_code (s_char_code),
        .s_read_row  (s_read_row),
        .s_read_col  (s_read_col),
        .s_block_end (s_block_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cursor_row(m_cursor_row),
        .m_cursor_col(m_cursor_col),
        .m_cell_value(m_cell_value),
        .m_bell      (m_bell),
        .m_scrolled  (m_scrolled),
        .m_block_done(m_block_done)
    );

    tts_screen_checker #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_char_code    (s_char_code),
        .s_read_row     (s_read_row),
        .s_read_col     (s_read_col),
        .s_block_end    (s_block_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_cursor_row   (m_cursor_row),
        .m_cursor_col   (m_cursor_col),
        .m_cell_value   (m_cell_value),
        .m_bell         (m_bell),
        .m_scrolled     (m_scrolled),
        .m_block_done   (m_block_done),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    // Receiver pacing. Mostly ready with short stalls, now and then a longer
    // stall or a calm stretch with no stall at all. A bump of hold_requests
    // forces one long hold so the block backs up and drops s_ready.
    always @(posedge aclk) begin
        int r;
        if (hold_seen != hold_requests) begin
            hold_seen  <= hold_requests;
            stall_left <= LONG_HOLD;
            m_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (ready_calm > 0) begin
            ready_calm <= ready_calm - 1;
            m_ready    <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                m_ready <= 1'b1;
            end else if (r < 85) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(0, 3);
            end else if (r < 95) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(8, 40);
            end else begin
                m_ready    <= 1'b1;
                ready_calm <= $urandom_range(20, 120);
            end
        end
    end

    // Watchdog: any beat or register write resets the idle count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Sender gap: mostly none, some short, a few long, occasional calm runs.
    function automatic int sender_gap();
        int r;
        if (gap_calm > 0) begin
            gap_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        if (r < 99) return $urandom_range(30, 80);
        gap_calm = $urandom_range(30, 150);
        return 0;
    endfunction

    // One input beat. Valid is only dropped when a gap follows, so back to
    // back beats keep it high without a second assignment in the same step.
    task automatic send_beat(input logic req, input logic [7:0] ch,
                             input logic [4:0] row, input logic [6:0] col,
                             input logic last);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_req_type  <= req;
        s_char_code <= ch;
        s_read_row  <= row;
        s_read_col  <= col;
        s_block_end <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic put_byte(input logic [7:0] ch, input logic last);
        send_beat(tts_pkg::REQ_PUT, ch, 5'($urandom_range(0, 31)),
                  7'($urandom_range(0, 127)), last);
    endtask

    task automatic read_cell(input logic [4:0] row, input logic [6:0] col,
                             input logic last);
        send_beat(tts_pkg::REQ_READ, 8'($urandom_range(0, 255)), row, col, last);
    endtask

    // APB write: setup then access, upper data bits random (only bit 0 counts).
    task automatic write_reg(input logic idx, input logic val);
        logic [31:0] data;
        data    = $urandom();
        data[0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
    endtask

    // Text byte: mostly printable, sometimes any byte that is not a control code.
    function automatic logic [7:0] text_byte();
        logic [7:0] ch;
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(8'h20, 8'h7E));
        do ch = 8'($urandom_range(0, 255));
        while (ch == tts_pkg::CODE_BEL || ch == tts_pkg::CODE_BS ||
               ch == tts_pkg::CODE_LF || ch == tts_pkg::CODE_CR);
        return ch;
    endfunction

    function automatic logic [7:0] control_byte();
        case ($urandom_range(0, 3))
            0:       return tts_pkg::CODE_BEL;
            1:       return tts_pkg::CODE_BS;
            2:       return tts_pkg::CODE_CR;
            default: return tts_pkg::CODE_LF;
        endcase
    endfunction

    // Directed opening: blank reads at the screen corners, extreme bytes,
    // BEL, backspace past column 0, CR and LF, then reading back what was put.
    task automatic directed_beats();
        read_cell(5'd0, 7'd0, 1'b0);
        read_cell(5'd31, 7'd127, 1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h41, 1'b1);
        put_byte(tts_pkg::CODE_BEL, 1'b0);
        repeat (4) put_byte(tts_pkg::CODE_BS, 1'b0);     // last one sticks at column 0
        read_cell(5'd0, 7'd0, 1'b0);
        read_cell(5'd0, 7'd1, 1'b0);
        read_cell(5'd0, 7'd2, 1'b1);
        put_byte(tts_pkg::CODE_CR, 1'b0);                // newline mode: row 1
        put_byte(tts_pkg::CODE_LF, 1'b0);                // row 2
        put_byte(8'h7E, 1'b0);
        put_byte(8'h80, 1'b1);
        read_cell(5'd2, 7'd0, 1'b0);
        read_cell(5'd2, 7'd1, 1'b0);
        read_cell(5'd31, 7'd0, 1'b0);
        read_cell(5'd0, 7'd127, 1'b1);
    endtask

    // Random traffic for one phase: text lines of varied length (some past the
    // last column to hit wrap), runs of line feeds to reach the bottom and
    // scroll, control mixes, reads and a share of fully random beats.
    task automatic random_beats(input int phase);
        int start;
        int kind;
        int len;
        int term;
        bit pressed;
        start   = beats_sent;
        pressed = 1'b0;
        while (beats_sent - start < PHASE_BEATS) begin
            if (phase % 2 == 1 && !pressed && beats_sent - start >= PHASE_BEATS / 2) begin
                hold_requests <= hold_requests + 1;
                pressed = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                term = $urandom_range(0, 99);
                if (term < 80)      len = $urandom_range(1, 40);
                else if (term < 92) len = $urandom_range(41, 126);
                else                len = $urandom_range(127, 140);
                for (int i = 0; i < len; i++) put_byte(text_byte(), i == len - 1);
                case ($urandom_range(0, 3))
                    0: ;
                    1: put_byte(tts_pkg::CODE_CR, 1'b0);
                    2: put_byte(tts_pkg::CODE_LF, 1'b0);
                    default: begin
                        put_byte(tts_pkg::CODE_CR, 1'b0);
                        put_byte(tts_pkg::CODE_LF, 1'b1);
                    end
                endcase
            end else if (kind < 58) begin
                len = $urandom_range(1, 35);
                repeat (len) put_byte(tts_pkg::CODE_LF, 1'($urandom_range(0, 1)));
            end else if (kind < 75) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    if ($urandom_range(0, 1))
                        read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
                                  1'($urandom_range(0, 1)));
                    else
                        read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 45)),
                                  1'($urandom_range(0, 1)));
                end
            end else if (kind < 87) begin
                len = $urandom_range(1, 6);
                repeat (len) put_byte(control_byte(), 1'($urandom_range(0, 1)));
            end else begin
                send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_req_type  = tts_pkg::REQ_PUT;
        s_char_code = '0;
        s_read_row  = '0;
        s_read_col  = '0;
        s_block_end = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Settings change only with nothing in flight. Every beat yields a
        // result, so an empty expectation queue means the block is idle.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) wait_drained();
            write_reg(tts_pkg::REG_NEWLINE, NEWLINE_PLAN[phase]);
            write_reg(tts_pkg::REG_AUTOWRAP, AUTOWRAP_PLAN[phase]);
            if (phase == 0) directed_beats();
            random_beats(phase);
            s_valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
